// ===== design/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared widths, codes, bus structs and helpers of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam int MAX_COLUMNS = 80;
	localparam int MAX_ROWS    = 50;
	localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;

	localparam int COL_W      = 7;
	localparam int ROW_W      = 6;
	localparam int ADDR_W     = 12;
	localparam int CELL_W     = 16;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 4;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int PROD_W     = ROW_W + COL_W;
	localparam int TAB_LOG    = 2;
	localparam int TAB_STOP   = 1 << TAB_LOG;
	localparam int TAB_W      = TAB_LOG + 1;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CELL_W-1:0]  cell_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [COL_W-1:0]   col_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [TAB_W-1:0]   tab_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	localparam char_t CH_BS    = 8'h08;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_NL    = 8'h0A;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_BLANK = 8'h20;

	localparam logic [CFG_IDX_W-1:0] REG_FG   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd3;

	localparam color_t RESET_FG   = 4'd7;
	localparam color_t RESET_BG   = 4'd0;
	localparam col_t   RESET_COLS = col_t'(MAX_COLUMNS);
	localparam row_t   RESET_ROWS = row_t'(MAX_ROWS);

	localparam addr_t DEPTH_LIMIT = addr_t'(STORE_DEPTH);
	localparam addr_t LAST_ENTRY  = addr_t'(STORE_DEPTH - 1);

	typedef struct packed {
		color_t fg;
		color_t bg;
		col_t   cols;
		row_t   rows;
	} cfg_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		cell_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	typedef struct packed {
		logic  valid;
		col_t  col;
		row_t  row;
		cell_t word;
	} res_t;

	function automatic cell_t make_cell(color_t bg, color_t fg, char_t ch);
		return {bg, fg, ch};
	endfunction

	localparam cell_t RESET_CELL = {RESET_BG, RESET_FG, CH_BLANK};

endpackage

// ===== design/tccw_if.sv =====
// ----------------------------------------------------------------------------
// tccw channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tccw_in_if;
	logic                                valid;
	logic                                ready;
	logic [tccw_pkg::CMD_W-1:0]          command;
	logic [tccw_pkg::CHAR_W-1:0]         char_code;
	logic [tccw_pkg::ADDR_W-1:0]         cell_address;

	modport source(output valid, command, char_code, cell_address, input ready);
	modport sink(input valid, command, char_code, cell_address, output ready);
endinterface

interface tccw_out_if;
	logic                                valid;
	logic                                ready;
	logic [tccw_pkg::COL_W-1:0]          cursor_column;
	logic [tccw_pkg::ROW_W-1:0]          cursor_row;
	logic [tccw_pkg::CELL_W-1:0]         cell_word;

	modport source(output valid, cursor_column, cursor_row, cell_word, input ready);
	modport sink(input valid, cursor_column, cursor_row, cell_word, output ready);
endinterface

interface tccw_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [tccw_pkg::CFG_IDX_W-1:0]      index;
	logic [tccw_pkg::CFG_DATA_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/tccw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tccw_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tccw_cell_ram (
	input  logic               clk,
	input  tccw_pkg::mem_req_t req,
	output tccw_pkg::cell_t    rdata
);

	tccw_pkg::cell_t mem [tccw_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== design/tccw_seq.sv =====
// ----------------------------------------------------------------------------
// tccw_seq
// Sequencer: cursor, command decode and the walks over
// the cell store (clearing pass, scroll copy, blank fill, cell writes).
// ----------------------------------------------------------------------------
module tccw_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tccw_pkg::CMD_W-1:0]     command,
	input  tccw_pkg::char_t                char_code,
	input  tccw_pkg::addr_t                cell_address,
	input  tccw_pkg::cfg_t                 cfg,
	input  logic                           res_free,
	output tccw_pkg::res_t                 res,
	output tccw_pkg::mem_req_t             mem_req,
	input  tccw_pkg::cell_t                rdata
);

	typedef enum logic [11:0] {
		ST_INIT   = 12'b0000_0000_0001,
		ST_IDLE   = 12'b0000_0000_0010,
		ST_DEC    = 12'b0000_0000_0100,
		ST_NL     = 12'b0000_0000_1000,
		ST_SCR    = 12'b0000_0001_0000,
		ST_CLR    = 12'b0000_0010_0000,
		ST_BLANK  = 12'b0000_0100_0000,
		ST_PUTSET = 12'b0000_1000_0000,
		ST_CELL   = 12'b0001_0000_0000,
		ST_BSW    = 12'b0010_0000_0000,
		ST_RDW    = 12'b0100_0000_0000,
		ST_DONE   = 12'b1000_0000_0000
	} state_t;

	state_t                      state_q;
	tccw_pkg::col_t              col_q;
	tccw_pkg::row_t              row_q;
	tccw_pkg::col_t              w_q;
	tccw_pkg::row_t              h_q;
	tccw_pkg::cmd_t              cmd_q;
	tccw_pkg::char_t             char_q;
	tccw_pkg::addr_t             addr_q;
	tccw_pkg::addr_t             last_base_q;
	tccw_pkg::addr_t             ptr_q;
	tccw_pkg::addr_t             cnt_q;
	tccw_pkg::tab_t              n_q;
	tccw_pkg::char_t             cell_char_q;
	logic                        after_put_q;
	tccw_pkg::cell_t             word_q;
	logic                        wr_vld_s1;
	tccw_pkg::addr_t             wr_addr_s1;

	tccw_pkg::col_t              w_sat;
	tccw_pkg::row_t              h_sat;
	logic [tccw_pkg::PROD_W-1:0] cur_lin;
	logic [tccw_pkg::PROD_W-1:0] base_prod;
	tccw_pkg::addr_t             cur_addr;
	tccw_pkg::cell_t             space_cell;
	tccw_pkg::col_t              col_inc;

	// width and height in use, saturated to the supported range
	always_comb begin
		if (cfg.cols == '0) begin
			w_sat = tccw_pkg::col_t'(1);
		end else if (cfg.cols > tccw_pkg::col_t'(tccw_pkg::MAX_COLUMNS)) begin
			w_sat = tccw_pkg::col_t'(tccw_pkg::MAX_COLUMNS);
		end else begin
			w_sat = cfg.cols;
		end
		if (cfg.rows == '0) begin
			h_sat = tccw_pkg::row_t'(1);
		end else if (cfg.rows > tccw_pkg::row_t'(tccw_pkg::MAX_ROWS)) begin
			h_sat = tccw_pkg::row_t'(tccw_pkg::MAX_ROWS);
		end else begin
			h_sat = cfg.rows;
		end
	end

	assign cur_lin = tccw_pkg::PROD_W'(row_q) * tccw_pkg::PROD_W'(w_q)
		+ tccw_pkg::PROD_W'(col_q);
	assign cur_addr = cur_lin[tccw_pkg::ADDR_W-1:0];
	assign base_prod = tccw_pkg::PROD_W'(h_q - tccw_pkg::row_t'(1))
		* tccw_pkg::PROD_W'(w_q);
	assign space_cell = tccw_pkg::make_cell(cfg.bg, cfg.fg, tccw_pkg::CH_BLANK);
	assign col_inc = col_q + tccw_pkg::col_t'(1);

	always_comb begin
		mem_req = '0;
		if (wr_vld_s1) begin
			// scroll copy: the registered read data goes one row up
			mem_req.we    = 1'b1;
			mem_req.waddr = wr_addr_s1;
			mem_req.wdata = rdata;
		end else begin
			case (state_q)
				ST_INIT: begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ptr_q;
					mem_req.wdata = tccw_pkg::RESET_CELL;
				end
				ST_BLANK: begin
					mem_req.we    = (cnt_q != '0);
					mem_req.waddr = ptr_q;
					mem_req.wdata = space_cell;
				end
				ST_CELL: begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cur_addr;
					mem_req.wdata = tccw_pkg::make_cell(cfg.bg, cfg.fg, cell_char_q);
				end
				ST_BSW: begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cur_addr;
					mem_req.wdata = space_cell;
				end
				default: ;
			endcase
		end
		if (state_q == ST_SCR && cnt_q != '0) begin
			mem_req.re    = 1'b1;
			mem_req.raddr = ptr_q;
		end else if (state_q == ST_DEC && cmd_q == tccw_pkg::CMD_READ
				&& addr_q < tccw_pkg::DEPTH_LIMIT) begin
			mem_req.re    = 1'b1;
			mem_req.raddr = addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			col_q       <= '0;
			row_q       <= '0;
			w_q         <= tccw_pkg::RESET_COLS;
			h_q         <= tccw_pkg::RESET_ROWS;
			cmd_q       <= tccw_pkg::CMD_PUT;
			char_q      <= '0;
			addr_q      <= '0;
			last_base_q <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			n_q         <= '0;
			cell_char_q <= '0;
			after_put_q <= 1'b0;
			word_q      <= '0;
			wr_vld_s1   <= 1'b0;
			wr_addr_s1  <= '0;
		end else begin
			wr_vld_s1  <= (state_q == ST_SCR) && (cnt_q != '0);
			wr_addr_s1 <= ptr_q - tccw_pkg::addr_t'(w_q);
			case (state_q)
				ST_INIT: begin
					if (ptr_q == tccw_pkg::LAST_ENTRY) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + tccw_pkg::addr_t'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						// pull the cursor back inside a screen that may have shrunk
						w_q         <= w_sat;
						h_q         <= h_sat;
						col_q       <= (col_q > w_sat) ? w_sat : col_q;
						row_q       <= (row_q > h_sat - tccw_pkg::row_t'(1))
							? h_sat - tccw_pkg::row_t'(1) : row_q;
						cmd_q       <= tccw_pkg::cmd_t'(command);
						char_q      <= char_code;
						addr_q      <= cell_address;
						word_q      <= '0;
						after_put_q <= 1'b0;
						state_q     <= ST_DEC;
					end
				end
				ST_DEC: begin
					last_base_q <= base_prod[tccw_pkg::ADDR_W-1:0];
					case (cmd_q)
						tccw_pkg::CMD_PUT: begin
							case (char_q)
								tccw_pkg::CH_NL: begin
									state_q <= ST_NL;
								end
								tccw_pkg::CH_CR: begin
									col_q   <= '0;
									state_q <= ST_DONE;
								end
								tccw_pkg::CH_BS: begin
									if (col_q != '0) begin
										col_q   <= col_q - tccw_pkg::col_t'(1);
										state_q <= ST_BSW;
									end else if (row_q != '0) begin
										// back across the line end
										row_q   <= row_q - tccw_pkg::row_t'(1);
										col_q   <= w_q - tccw_pkg::col_t'(1);
										state_q <= ST_BSW;
									end else begin
										state_q <= ST_DONE;
									end
								end
								default: begin
									if (col_q >= w_q) begin
										// pending wrap: new line first
										after_put_q <= 1'b1;
										state_q     <= ST_NL;
									end else begin
										state_q <= ST_PUTSET;
									end
								end
							endcase
						end
						tccw_pkg::CMD_CLEAR: begin
							col_q   <= '0;
							row_q   <= '0;
							state_q <= ST_CLR;
						end
						tccw_pkg::CMD_READ: begin
							state_q <= (addr_q < tccw_pkg::DEPTH_LIMIT) ? ST_RDW : ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_NL: begin
					col_q <= '0;
					if (row_q < h_q - tccw_pkg::row_t'(1)) begin
						row_q   <= row_q + tccw_pkg::row_t'(1);
						state_q <= after_put_q ? ST_PUTSET : ST_DONE;
					end else begin
						ptr_q   <= tccw_pkg::addr_t'(w_q);
						cnt_q   <= last_base_q;
						state_q <= ST_SCR;
					end
				end
				ST_SCR: begin
					if (cnt_q != '0) begin
						ptr_q <= ptr_q + tccw_pkg::addr_t'(1);
						cnt_q <= cnt_q - tccw_pkg::addr_t'(1);
					end else begin
						// copy finished, blank the last row
						ptr_q   <= last_base_q;
						cnt_q   <= tccw_pkg::addr_t'(w_q);
						state_q <= ST_BLANK;
					end
				end
				ST_CLR: begin
					ptr_q   <= '0;
					cnt_q   <= last_base_q + tccw_pkg::addr_t'(w_q);
					state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					if (cnt_q != '0) begin
						ptr_q <= ptr_q + tccw_pkg::addr_t'(1);
						cnt_q <= cnt_q - tccw_pkg::addr_t'(1);
					end else begin
						state_q <= after_put_q ? ST_PUTSET : ST_DONE;
					end
				end
				ST_PUTSET: begin
					if (char_q == tccw_pkg::CH_TAB) begin
						n_q         <= tccw_pkg::tab_t'(tccw_pkg::TAB_STOP)
							- tccw_pkg::tab_t'(col_q[tccw_pkg::TAB_LOG-1:0]);
						cell_char_q <= tccw_pkg::CH_BLANK;
					end else begin
						n_q         <= tccw_pkg::tab_t'(1);
						cell_char_q <= char_q;
					end
					state_q <= ST_CELL;
				end
				ST_CELL: begin
					col_q <= col_inc;
					n_q   <= n_q - tccw_pkg::tab_t'(1);
					// tab stops at the next stop or at the row end
					if (n_q == tccw_pkg::tab_t'(1) || col_inc >= w_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_BSW: begin
					state_q <= ST_DONE;
				end
				ST_RDW: begin
					word_q  <= rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_DONE) && res_free;
	assign res.col   = col_q;
	assign res.row   = row_q;
	assign res.word  = word_q;

	a_copy_only_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_s1 |-> state_q == ST_SCR)
		else $error("scroll copy write outside scroll walk");

	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> mem_req.waddr < tccw_pkg::DEPTH_LIMIT)
		else $error("cell write beyond the store");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> (row_q < h_q) && (col_q <= w_q))
		else $error("cursor off screen at end of request");

	a_read_before_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RDW |-> $past(mem_req.re))
		else $error("read data captured without a read");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DEC)
		else $error("accepted request not decoded");

endmodule

// ===== design/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text console: 4000-cell character store with cursor, put/clear/read
// requests, color and screen size registers.
//
//  channel  | dir | fields
//  ---------+-----+---------------------------------------------------
//  in_ch    | in  | command, char_code, cell_address
//  out_ch   | out | cursor_column, cursor_row, cell_word
//  cfg_ch   | in  | index, data (always ready)
//
// A clear blanks the w*h cells in use and a newline on the last row copies
// the rows one up and blanks the last, each walking the store through its
// single write port (w, h the size in use); a put on a pending wrap makes
// that newline first.
// After reset a clearing pass fills the store; no request is taken
// meanwhile, register writes are. One request is worked at a time; the
// result register lets the next request in while a result waits on out_ch.
// ----------------------------------------------------------------------------
module text_console_cell_writer (
	input  logic       clk,
	input  logic       arst_n,
	tccw_in_if.sink    in_ch,
	tccw_out_if.source out_ch,
	tccw_cfg_if.sink   cfg_ch
);

	tccw_pkg::cfg_t     cfg_q;
	tccw_pkg::res_t     res;
	tccw_pkg::mem_req_t mem_req;
	tccw_pkg::cell_t    rdata;
	logic               res_free;
	logic               out_valid_q;
	tccw_pkg::col_t     out_col_q;
	tccw_pkg::row_t     out_row_q;
	tccw_pkg::cell_t    out_word_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg   <= tccw_pkg::RESET_FG;
			cfg_q.bg   <= tccw_pkg::RESET_BG;
			cfg_q.cols <= tccw_pkg::RESET_COLS;
			cfg_q.rows <= tccw_pkg::RESET_ROWS;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				tccw_pkg::REG_FG:   cfg_q.fg   <= cfg_ch.data[tccw_pkg::COLOR_W-1:0];
				tccw_pkg::REG_BG:   cfg_q.bg   <= cfg_ch.data[tccw_pkg::COLOR_W-1:0];
				tccw_pkg::REG_COLS: cfg_q.cols <= cfg_ch.data[tccw_pkg::COL_W-1:0];
				tccw_pkg::REG_ROWS: cfg_q.rows <= cfg_ch.data[tccw_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	tccw_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.command      (in_ch.command),
		.char_code    (in_ch.char_code),
		.cell_address (in_ch.cell_address),
		.cfg          (cfg_q),
		.res_free     (res_free),
		.res          (res),
		.mem_req      (mem_req),
		.rdata        (rdata)
	);

	tccw_cell_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	assign res_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_word_q  <= '0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
			out_col_q   <= res.col;
			out_row_q   <= res.row;
			out_word_q  <= res.word;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.cursor_column = out_col_q;
	assign out_ch.cursor_row    = out_row_q;
	assign out_ch.cell_word     = out_word_q;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer testbench
// Drives put, clear and read requests through a shadow console that tracks
// the cell store, the cursor and the color and size registers. Each result is
// checked field by field against the shadow, over small and full screens,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [tccw_pkg::CMD_W-1:0]      cmd_code_t;
	typedef logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data_t;

	localparam cmd_code_t CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		tccw_pkg::col_t  col;
		tccw_pkg::row_t  row;
		tccw_pkg::cell_t word;
	} console_view_t;

	logic clk = 1'b0;
	logic arst_n;

	tccw_in_if  in_ch();
	tccw_out_if out_ch();
	tccw_cfg_if cfg_ch();

	text_console_cell_writer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always #5 clk = ~clk;

	// shadow console
	tccw_pkg::cell_t  shadow_cells [tccw_pkg::STORE_DEPTH];
	int               shadow_col;
	int               shadow_row;
	tccw_pkg::color_t shadow_fg;
	tccw_pkg::color_t shadow_bg;
	tccw_pkg::col_t   shadow_cols;
	tccw_pkg::row_t   shadow_rows;

	console_view_t awaited_views [$];
	int            mismatch_count = 0;
	bit            stall_on = 1'b0;

	function automatic int screen_width();
		int w;
		w = shadow_cols;
		if (w < 1) w = 1;
		if (w > tccw_pkg::MAX_COLUMNS) w = tccw_pkg::MAX_COLUMNS;
		return w;
	endfunction

	function automatic int screen_height();
		int h;
		h = shadow_rows;
		if (h < 1) h = 1;
		if (h > tccw_pkg::MAX_ROWS) h = tccw_pkg::MAX_ROWS;
		return h;
	endfunction

	function automatic void store_glyph(int row, int col, int w, tccw_pkg::char_t ch);
		int idx;
		idx = row * w + col;
		if (idx < tccw_pkg::STORE_DEPTH) shadow_cells[idx] = {shadow_bg, shadow_fg, ch};
	endfunction

	function automatic void line_feed(int w, int h);
		int i;
		if (shadow_row < h - 1) begin
			shadow_row++;
		end else begin
			// scroll up one row, blank the bottom one
			for (i = 0; i < (h - 1) * w && i + w < tccw_pkg::STORE_DEPTH; i++)
				shadow_cells[i] = shadow_cells[i + w];
			for (i = 0; i < w; i++)
				store_glyph(h - 1, i, w, tccw_pkg::CH_BLANK);
		end
		shadow_col = 0;
	endfunction

	function automatic console_view_t advance_console(cmd_code_t cmd, tccw_pkg::char_t ch,
			tccw_pkg::addr_t addr);
		int w;
		int h;
		int n;
		int i;
		console_view_t v;
		w = screen_width();
		h = screen_height();
		// cursor may sit outside a screen that was made smaller
		if (shadow_col > w) shadow_col = w;
		if (shadow_row > h - 1) shadow_row = h - 1;
		v.word = '0;
		case (cmd)
			tccw_pkg::CMD_PUT: begin
				case (ch)
					tccw_pkg::CH_NL: line_feed(w, h);
					tccw_pkg::CH_CR: shadow_col = 0;
					tccw_pkg::CH_BS: begin
						if (shadow_col == 0 && shadow_row != 0) begin
							shadow_row--;
							shadow_col = w;
						end
						if (shadow_col > 0) begin
							shadow_col--;
							store_glyph(shadow_row, shadow_col, w, tccw_pkg::CH_BLANK);
						end
					end
					tccw_pkg::CH_TAB: begin
						if (shadow_col >= w) line_feed(w, h);
						n = tccw_pkg::TAB_STOP - shadow_col % tccw_pkg::TAB_STOP;
						while (n != 0 && shadow_col < w) begin
							store_glyph(shadow_row, shadow_col, w, tccw_pkg::CH_BLANK);
							shadow_col++;
							n--;
						end
					end
					default: begin
						// late wrap
						if (shadow_col >= w) line_feed(w, h);
						store_glyph(shadow_row, shadow_col, w, ch);
						shadow_col++;
					end
				endcase
			end
			tccw_pkg::CMD_CLEAR: begin
				for (i = 0; i < w * h && i < tccw_pkg::STORE_DEPTH; i++)
					store_glyph(0, i, w, tccw_pkg::CH_BLANK);
				shadow_col = 0;
				shadow_row = 0;
			end
			tccw_pkg::CMD_READ: begin
				if (addr < tccw_pkg::STORE_DEPTH) v.word = shadow_cells[addr];
			end
			default: ;
		endcase
		v.col = tccw_pkg::col_t'(shadow_col);
		v.row = tccw_pkg::row_t'(shadow_row);
		return v;
	endfunction

	function automatic int idle_length();
		int r;
		if (!stall_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic cfg_data_t pick_extent(int full, int top, int modest);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return cfg_data_t'(1);
			2: return cfg_data_t'(full);
			3: return cfg_data_t'($urandom_range(full + 1, top));
			default: return cfg_data_t'($urandom_range(2, modest));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_request(input cmd_code_t cmd, input tccw_pkg::char_t ch,
			input tccw_pkg::addr_t addr);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.command      <= cmd;
		in_ch.char_code    <= ch;
		in_ch.cell_address <= addr;
		do @(posedge clk); while (!in_ch.ready);
		awaited_views.push_back(advance_console(cmd, ch, addr));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (awaited_views.size() != 0) @(posedge clk);
	endtask

	// registers are only written with the console idle
	task automatic set_screen(input cfg_data_t fg, input cfg_data_t bg,
			input cfg_data_t cols, input cfg_data_t rows);
		logic [tccw_pkg::CFG_IDX_W-1:0] regs [4];
		cfg_data_t                      vals [4];
		regs = '{tccw_pkg::REG_FG, tccw_pkg::REG_BG, tccw_pkg::REG_COLS, tccw_pkg::REG_ROWS};
		vals = '{fg, bg, cols, rows};
		drain();
		for (int k = 0; k < 4; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[k];
			cfg_ch.data  <= vals[k];
			do @(posedge clk); while (!cfg_ch.ready);
			case (regs[k])
				tccw_pkg::REG_FG:   shadow_fg   = vals[k][tccw_pkg::COLOR_W-1:0];
				tccw_pkg::REG_BG:   shadow_bg   = vals[k][tccw_pkg::COLOR_W-1:0];
				tccw_pkg::REG_COLS: shadow_cols = vals[k][tccw_pkg::COL_W-1:0];
				tccw_pkg::REG_ROWS: shadow_rows = vals[k][tccw_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_random(input bit sparse_lines);
		int r;
		int area;
		cmd_code_t cmd;
		tccw_pkg::char_t ch;
		tccw_pkg::addr_t addr;
		area = screen_width() * screen_height();
		ch   = tccw_pkg::char_t'($urandom_range(0, 255));
		addr = tccw_pkg::addr_t'($urandom_range(0, 4095));
		cmd  = tccw_pkg::CMD_PUT;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			cmd = tccw_pkg::CMD_READ;
			if ($urandom_range(0, 3) != 0)
				addr = tccw_pkg::addr_t'($urandom_range(0, area - 1));
		end else if (r < 17) begin
			cmd = CMD_UNUSED;
		end else if (r < (sparse_lines ? 18 : 20)) begin
			cmd = tccw_pkg::CMD_CLEAR;
		end else begin
			r = $urandom_range(0, 99);
			if (r < (sparse_lines ? 2 : 12)) ch = tccw_pkg::CH_NL;
			else if (r < 20) ch = tccw_pkg::CH_CR;
			else if (r < 32) ch = tccw_pkg::CH_BS;
			else if (r < 44) ch = tccw_pkg::CH_TAB;
		end
		send_request(cmd, ch, addr);
	endtask

	task automatic test_directed_cases();
		stall_on = 1'b0;
		// oversize width and height saturate to the full screen
		set_screen(7'h0F, 7'h00, 7'd127, 7'd63);
		send_request(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, '0);
		send_request(tccw_pkg::CMD_PUT, 8'h00, '0);
		send_request(tccw_pkg::CMD_PUT, 8'hFF, 12'hFFF);
		send_request(tccw_pkg::CMD_READ, 8'h00, 12'd0);
		send_request(tccw_pkg::CMD_READ, 8'h00, 12'd1);
		send_request(tccw_pkg::CMD_READ, 8'hFF, tccw_pkg::LAST_ENTRY);
		send_request(tccw_pkg::CMD_READ, 8'h00, 12'hFFF);
		send_request(CMD_UNUSED, 8'hFF, 12'hFFF);
		// zero size saturates to one cell, cursor lands on a pending wrap
		set_screen(7'h00, 7'h7F, 7'd0, 7'd0);
		send_request(tccw_pkg::CMD_PUT, 8'h41, '0);
		send_request(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, '0);
		send_request(tccw_pkg::CMD_PUT, tccw_pkg::CH_NL, '0);
		send_request(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, '0);
		send_request(tccw_pkg::CMD_READ, 8'h00, 12'd0);
		set_screen(7'h07, 7'h01, 7'd5, 7'd3);
		send_request(tccw_pkg::CMD_PUT, 8'h61, '0);
		send_request(tccw_pkg::CMD_PUT, 8'h62, '0);
		send_request(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, '0);
		send_request(tccw_pkg::CMD_PUT, tccw_pkg::CH_CR, '0);
		send_request(tccw_pkg::CMD_PUT, tccw_pkg::CH_NL, '0);
		// backspace from the start of a row steps onto the row above
		send_request(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, '0);
		send_request(tccw_pkg::CMD_READ, 8'h00, 12'd4);
		send_request(tccw_pkg::CMD_CLEAR, 8'h00, '0);
		send_request(tccw_pkg::CMD_READ, 8'h00, 12'd0);
	endtask

	task automatic test_small_screens();
		for (int phase = 0; phase < 20; phase++) begin
			stall_on = (phase % 4 != 0);
			set_screen(cfg_data_t'($urandom_range(0, 127)), cfg_data_t'($urandom_range(0, 127)),
				pick_extent(tccw_pkg::MAX_COLUMNS, 127, 12),
				pick_extent(tccw_pkg::MAX_ROWS, 63, 6));
			repeat ($urandom_range(55, 75)) send_random(1'b0);
		end
	endtask

	task automatic test_full_screen();
		for (int k = 0; k < 2; k++) begin
			stall_on = k[0];
			set_screen(cfg_data_t'($urandom_range(0, 127)), cfg_data_t'($urandom_range(0, 127)),
				k ? 7'd127 : 7'd80, k ? 7'd63 : 7'd50);
			repeat (75) send_random(1'b1);
		end
	endtask

	always @(posedge clk) begin : cursor_check
		console_view_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited_views.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				want = awaited_views.pop_front();
				if (out_ch.cursor_column !== want.col)
					report_mismatch($sformatf("cursor_column %0d, want %0d",
						out_ch.cursor_column, want.col));
				if (out_ch.cursor_row !== want.row)
					report_mismatch($sformatf("cursor_row %0d, want %0d",
						out_ch.cursor_row, want.row));
				if (out_ch.cell_word !== want.word)
					report_mismatch($sformatf("cell_word %04h, want %04h",
						out_ch.cell_word, want.word));
			end
		end
	end

	initial begin : result_stall
		int n;
		out_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			n = idle_length();
			if (n == 0) begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("text_console_cell_writer test failed");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.command      = tccw_pkg::CMD_PUT;
		in_ch.char_code    = '0;
		in_ch.cell_address = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = tccw_pkg::REG_FG;
		cfg_ch.data        = '0;
		for (int i = 0; i < tccw_pkg::STORE_DEPTH; i++) shadow_cells[i] = tccw_pkg::RESET_CELL;
		shadow_col  = 0;
		shadow_row  = 0;
		shadow_fg   = tccw_pkg::RESET_FG;
		shadow_bg   = tccw_pkg::RESET_BG;
		shadow_cols = tccw_pkg::RESET_COLS;
		shadow_rows = tccw_pkg::RESET_ROWS;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_small_screens();
		test_full_screen();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("text_console_cell_writer test passed");
		else
			$display("text_console_cell_writer test failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/tccw_pkg.sv
design/tccw_if.sv
design/tccw_cell_ram.sv
design/tccw_seq.sv
design/text_console_cell_writer.sv
bench/testbench.sv
